/* rtl/srm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

    localparam int KEY_BITS            = 48;
    localparam int REF_BITS            = 32;
    localparam int CFG_BITS            = 4;
    localparam int MAX_SHADOW_RUNS_DEF = 8;

    localparam logic [1:0] KIND_OLD    = 2'd0;
    localparam logic [1:0] KIND_NEW    = 2'd1;
    localparam logic [1:0] KIND_SHADOW = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [2:0]          shadow_level;
        logic                at_end;
        logic [KEY_BITS-1:0] key;
        logic [REF_BITS-1:0] entry_ref;
        logic                is_dead;
    } in_word_t;

    typedef struct packed {
        logic                emit_valid;
        logic [KEY_BITS-1:0] emit_key;
        logic [REF_BITS-1:0] emit_ref;
        logic                emit_dead;
        logic [1:0]          need_kind;
        logic [2:0]          need_level;
        logic                merge_done;
    } out_word_t;

    // Word after the front has sorted it by source.
    typedef struct packed {
        logic                is_old;
        logic                is_new;
        logic                is_shadow;
        logic [2:0]          level;
        logic                at_end;
        logic [KEY_BITS-1:0] key;
        logic [REF_BITS-1:0] entry_ref;
        logic                is_dead;
    } cls_word_t;

endpackage

`default_nettype wire

/* rtl/sorted_run_merge_with_shadows.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-way merge of key-sorted old and new runs with a shadow filter. The
// feeder sends words on demand: every result word names the stream wanted
// next (need_kind, need_level) or reports merge_done, and may carry one
// merged entry. Equal keys let the new entry win and consume both heads; a
// candidate that matches a key in any of the first shadow_levels_used shadow
// runs is dropped. Words arriving from a stream other than the one asked for
// are ignored and the request is repeated. A front queue of two words takes
// input while the merge engine works; the engine handles one word at a time
// and steps one shadow head per cycle. A word may wait in the queue behind
// earlier words, and its result word may wait on a stalled output. The result
// sits in an output register, so a stalled consumer does not stop the front
// until its two-word queue fills. Write the config register only while the
// block is idle.
module sorted_run_merge_with_shadows #(
    parameter int MAX_SHADOW_RUNS = srm_pkg::MAX_SHADOW_RUNS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  srm_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output srm_pkg::out_word_t           out_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [srm_pkg::CFG_BITS-1:0]  cfg_data
);
    import srm_pkg::*;

    logic [CFG_BITS-1:0] levels_reg;
    logic                q_valid;
    logic                q_pop;
    cls_word_t           q_word;

    // Config register always accepts a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
        end
        else if (cfg_valid)
        begin
            levels_reg <= cfg_data;
        end
    end

    // Front: classify and queue incoming words.
    srm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    // Back: merge engine and output register.
    srm_back #(
        .MAX_SHADOW_RUNS (MAX_SHADOW_RUNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .levels_cfg (levels_reg),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

/* rtl/srm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module srm_front (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  srm_pkg::in_word_t       in_data,
    output logic                    q_valid,
    output srm_pkg::cls_word_t      q_word,
    input  wire                     q_pop
);
    import srm_pkg::*;

    cls_word_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cls_word_t  cls;
    logic       push;

    // Classify by source; an unknown kind matches no stream.
    always_comb
    begin
        cls.is_old    = (in_data.kind == KIND_OLD);
        cls.is_new    = (in_data.kind == KIND_NEW);
        cls.is_shadow = (in_data.kind == KIND_SHADOW);
        cls.level     = in_data.shadow_level;
        cls.at_end    = in_data.at_end;
        cls.key       = in_data.key;
        cls.entry_ref = in_data.entry_ref;
        cls.is_dead   = in_data.is_dead;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

`default_nettype wire

/* rtl/srm_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module srm_back #(
    parameter int MAX_SHADOW_RUNS = srm_pkg::MAX_SHADOW_RUNS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire [srm_pkg::CFG_BITS-1:0]    levels_cfg,
    input  wire                            q_valid,
    input  srm_pkg::cls_word_t             q_word,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire                            out_ready,
    output srm_pkg::out_word_t             out_data
);
    import srm_pkg::*;

    localparam int NS   = (MAX_SHADOW_RUNS > 0) ? MAX_SHADOW_RUNS : 1;
    localparam int IW   = (NS > 1) ? $clog2(NS) : 1;
    localparam int CL_W = (MAX_SHADOW_RUNS < 1) ? 1 : $clog2(MAX_SHADOW_RUNS + 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t              state_reg;
    logic [KEY_BITS-1:0] old_key_reg, new_key_reg;
    logic [REF_BITS-1:0] old_ref_reg, new_ref_reg;
    logic                old_dead_reg, new_dead_reg;
    logic                old_full_reg, new_full_reg, old_end_reg, new_end_reg;
    logic [KEY_BITS-1:0] shd_key_reg [NS];
    logic [NS-1:0]       shd_full_reg, shd_end_reg;
    logic [CL_W-1:0]     check_level_reg;
    logic                em_valid_reg, em_dead_reg;
    logic [KEY_BITS-1:0] em_key_reg;
    logic [REF_BITS-1:0] em_ref_reg;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    logic [CFG_BITS-1:0] used_w;
    logic [CL_W-1:0]     used;
    logic [IW-1:0]       cl_idx;
    logic                cl_in, s_full, s_end, shd_need, shd_less, shd_eq;
    logic                need_old, need_new, both_end, take_old, take_new;
    logic                match, out_free, report;
    logic [KEY_BITS-1:0] ckey, s_key;
    logic [REF_BITS-1:0] cref;
    logic                cdead;

    always_comb
    begin
        used_w   = (levels_cfg > CFG_BITS'(MAX_SHADOW_RUNS)) ?
                   CFG_BITS'(MAX_SHADOW_RUNS) : levels_cfg;
        used     = CL_W'(used_w);
        cl_idx   = check_level_reg[IW-1:0];
        cl_in    = (check_level_reg < used);
        s_full   = shd_full_reg[cl_idx];
        s_end    = shd_end_reg[cl_idx];
        s_key    = shd_key_reg[cl_idx];
        need_old = !old_full_reg && !old_end_reg;
        need_new = !need_old && !new_full_reg && !new_end_reg;
        both_end = old_end_reg && new_end_reg;
        take_old = !new_full_reg || (old_full_reg && (old_key_reg <= new_key_reg));
        take_new = new_full_reg && (!old_full_reg || (new_key_reg <= old_key_reg));
        ckey     = take_new ? new_key_reg  : old_key_reg;
        cref     = take_new ? new_ref_reg  : old_ref_reg;
        cdead    = take_new ? new_dead_reg : old_dead_reg;
        shd_need = cl_in && !s_full && !s_end;
        shd_less = s_full && (s_key < ckey);
        shd_eq   = s_full && (s_key == ckey);
        report   = need_old || need_new || both_end || (cl_in && shd_need);
        match    = (q_word.is_old && need_old) ||
                   (q_word.is_new && need_new) ||
                   (q_word.is_shadow && !need_old && !need_new && !both_end && shd_need &&
                    ({1'b0, q_word.level} == 4'(check_level_reg)));
        out_free = !out_valid_reg || out_ready;
    end

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Payload stores: no reset, read only behind their full bits.
    always_ff @(posedge clk)
    begin
        if (q_pop && match && !q_word.at_end)
        begin
            if (q_word.is_old)
            begin
                old_key_reg  <= q_word.key;
                old_ref_reg  <= q_word.entry_ref;
                old_dead_reg <= q_word.is_dead;
            end
            if (q_word.is_new)
            begin
                new_key_reg  <= q_word.key;
                new_ref_reg  <= q_word.entry_ref;
                new_dead_reg <= q_word.is_dead;
            end
            if (q_word.is_shadow)
            begin
                shd_key_reg[cl_idx] <= q_word.key;
            end
        end
        if (state_reg == ST_RUN && !need_old && !need_new && !both_end &&
            !(cl_in && (shd_need || shd_less || shd_eq)))
        begin
            em_key_reg  <= ckey;
            em_ref_reg  <= cref;
            em_dead_reg <= cdead;
        end
        if (state_reg == ST_RUN && out_free && (need_old || need_new || both_end ||
            (cl_in && shd_need)))
        begin
            out_data_reg.emit_valid <= em_valid_reg;
            out_data_reg.emit_key   <= em_valid_reg ? em_key_reg : '0;
            out_data_reg.emit_ref   <= em_valid_reg ? em_ref_reg : '0;
            out_data_reg.emit_dead  <= em_valid_reg && em_dead_reg;
            out_data_reg.merge_done <= !need_old && !need_new && both_end;
            out_data_reg.need_kind  <= need_old ? KIND_OLD :
                                       need_new ? KIND_NEW :
                                       both_end ? KIND_OLD : KIND_SHADOW;
            out_data_reg.need_level <= (!need_old && !need_new && !both_end) ?
                                       3'(cl_idx) : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            old_full_reg    <= 1'b0;
            new_full_reg    <= 1'b0;
            old_end_reg     <= 1'b0;
            new_end_reg     <= 1'b0;
            shd_full_reg    <= '0;
            shd_end_reg     <= '0;
            check_level_reg <= '0;
            em_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_RUN && report && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Apply the popped word if it is the stream asked for.
                    if (q_pop)
                    begin
                        if (match)
                        begin
                            if (q_word.is_old)
                            begin
                                if (q_word.at_end) old_end_reg  <= 1'b1;
                                else               old_full_reg <= 1'b1;
                            end
                            if (q_word.is_new)
                            begin
                                if (q_word.at_end) new_end_reg  <= 1'b1;
                                else               new_full_reg <= 1'b1;
                            end
                            if (q_word.is_shadow)
                            begin
                                shd_full_reg[cl_idx] <= !q_word.at_end;
                                if (q_word.at_end) shd_end_reg[cl_idx] <= 1'b1;
                            end
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (report)
                    begin
                        // Hold until the output register is free, then report.
                        if (out_free)
                        begin
                            em_valid_reg  <= 1'b0;
                            state_reg     <= ST_IDLE;
                            if (!need_old && !need_new && both_end)
                            begin
                                old_full_reg    <= 1'b0;
                                new_full_reg    <= 1'b0;
                                old_end_reg     <= 1'b0;
                                new_end_reg     <= 1'b0;
                                shd_full_reg    <= '0;
                                shd_end_reg     <= '0;
                                check_level_reg <= '0;
                            end
                        end
                    end
                    else if (cl_in && shd_less)
                    begin
                        shd_full_reg[cl_idx] <= 1'b0;
                    end
                    else if (cl_in && !shd_eq)
                    begin
                        check_level_reg <= check_level_reg + CL_W'(1);
                    end
                    else
                    begin
                        // Candidate resolved: emit unless shadowed, consume heads.
                        em_valid_reg    <= !cl_in;
                        check_level_reg <= '0;
                        if (take_old) old_full_reg <= 1'b0;
                        if (take_new) new_full_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/srm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module srm_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  srm_pkg::out_word_t  out_data
);
    import srm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_done_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.merge_done |-> !out_data.emit_valid &&
        out_data.need_kind == KIND_OLD)
        else $error("merge end carries an entry or a request");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.emit_valid |-> out_data.emit_key == '0 &&
        out_data.emit_ref == '0 && !out_data.emit_dead)
        else $error("empty result has entry fields set");

    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.need_kind != KIND_SHADOW |-> out_data.need_level == 3'd0)
        else $error("level set on a non-shadow request");

endmodule

bind sorted_run_merge_with_shadows srm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
